FILE: rtl/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, register indexes and compensation constants.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int DATA_W   = 32;
   localparam int UT_W     = 16;
   localparam int UP_W     = 19;
   localparam int OSS_W    = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_AC1_AC2  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AC3_AC4  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AC5_AC6  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B1_B2    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MC_MD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OSS      = 3'd5;

   localparam logic [DATA_W-1:0] B6_OFFSET  = 32'd4000;
   localparam logic [DATA_W-1:0] K_3038     = 32'd3038;
   localparam logic [DATA_W-1:0] K_7357     = 32'd7357;
   localparam logic [DATA_W-1:0] K_3791     = 32'd3791;
   localparam logic [DATA_W-1:0] K_50000    = 32'd50000;
   localparam logic [DATA_W-1:0] K_32768    = 32'd32768;

endpackage

FILE: rtl/bpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband payload that travels alongside each request.
// ----------------------------------------------------------------------------
module bpc_div #(
   parameter int DATA_W = bpc_pkg::DATA_W,
   parameter int PAY_W  = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DATA_W-1:0] in_num,
   input  logic [DATA_W-1:0] in_den,
   input  logic [PAY_W-1:0]  in_pay,
   output logic              out_valid,
   output logic [DATA_W-1:0] out_quo,
   output logic [PAY_W-1:0]  out_pay
);

   logic              v_ff   [0:DATA_W];
   logic [DATA_W-1:0] rem_ff [0:DATA_W];
   logic [DATA_W-1:0] num_ff [0:DATA_W];
   logic [DATA_W-1:0] quo_ff [0:DATA_W];
   logic [DATA_W-1:0] den_ff [0:DATA_W];
   logic [PAY_W-1:0]  pay_ff [0:DATA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0] <= '0;
         num_ff[0] <= in_num;
         quo_ff[0] <= '0;
         den_ff[0] <= in_den;
         pay_ff[0] <= in_pay;
      end
   end

   for (genvar k = 0; k < DATA_W; k++) begin : g_stage
      logic [DATA_W:0] shifted_in;
      logic [DATA_W:0] trial_in;
      logic            fits_in;

      assign shifted_in = {rem_ff[k], num_ff[k][DATA_W-1]};
      assign trial_in   = shifted_in - {1'b0, den_ff[k]};
      assign fits_in    = ~trial_in[DATA_W];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en) begin
            rem_ff[k+1] <= fits_in ? trial_in[DATA_W-1:0] : shifted_in[DATA_W-1:0];
            num_ff[k+1] <= {num_ff[k][DATA_W-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][DATA_W-2:0], fits_in};
            den_ff[k+1] <= den_ff[k];
            pay_ff[k+1] <= pay_ff[k];
         end
      end
   end

   assign out_valid = v_ff[DATA_W];
   assign out_quo   = quo_ff[DATA_W];
   assign out_pay   = pay_ff[DATA_W];

endmodule

FILE: rtl/barometric_pressure_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_top
// Integer pressure compensation from raw temperature and pressure words.
// ----------------------------------------------------------------------------
// Accepts one request per cycle while the output is not stalled and returns
// one compensated pressure per request, in order. The pipeline has 77
// register stages: two 33-stage bit-per-stage dividers, plus the input,
// multiply and output stages around them. The whole pipeline advances
// whenever the output register is empty or being taken; a stalled response
// holds every stage. A zero divisor gives pressure 0 with divide_error set.
// The user must write calibration registers through the csr port only
// while no request is in flight; the block itself does not enforce this.
module barometric_pressure_compensation_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bpc_pkg::UT_W-1:0]            req_raw_temperature,
   input  logic [bpc_pkg::UP_W-1:0]            req_raw_pressure,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bpc_pkg::DATA_W-1:0]   rsp_pressure_pa,
   output logic                                rsp_divide_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpc_pkg::DATA_W-1:0]          csr_data
);

   localparam int W  = bpc_pkg::DATA_W;
   localparam int UW = bpc_pkg::UP_W;
   localparam int PA_W = 1 + UW + W + 1;

   logic [W-1:0] ac1_ac2_ff, ac3_ac4_ff, ac5_ac6_ff, b1_b2_ff, mc_md_ff;
   logic [bpc_pkg::OSS_W-1:0] oss_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac2_ff <= '0;
         ac3_ac4_ff <= '0;
         ac5_ac6_ff <= '0;
         b1_b2_ff   <= '0;
         mc_md_ff   <= '0;
         oss_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            bpc_pkg::CSR_AC1_AC2: ac1_ac2_ff <= csr_data;
            bpc_pkg::CSR_AC3_AC4: ac3_ac4_ff <= csr_data;
            bpc_pkg::CSR_AC5_AC6: ac5_ac6_ff <= csr_data;
            bpc_pkg::CSR_B1_B2:   b1_b2_ff   <= csr_data;
            bpc_pkg::CSR_MC_MD:   mc_md_ff   <= csr_data;
            bpc_pkg::CSR_OSS:     oss_ff     <= csr_data[bpc_pkg::OSS_W-1:0];
            default: ;
         endcase
      end
   end

   logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{ac1_ac2_ff[31]}}, ac1_ac2_ff[31:16]};
   assign ac2 = {{16{ac1_ac2_ff[15]}}, ac1_ac2_ff[15:0]};
   assign ac3 = {{16{ac3_ac4_ff[31]}}, ac3_ac4_ff[31:16]};
   assign ac4 = {16'd0, ac3_ac4_ff[15:0]};
   assign ac5 = {16'd0, ac5_ac6_ff[31:16]};
   assign ac6 = {16'd0, ac5_ac6_ff[15:0]};
   assign b1  = {{16{b1_b2_ff[31]}}, b1_b2_ff[31:16]};
   assign b2  = {{16{b1_b2_ff[15]}}, b1_b2_ff[15:0]};
   assign mc  = {{16{mc_md_ff[31]}}, mc_md_ff[31:16]};
   assign md  = {{16{mc_md_ff[15]}}, mc_md_ff[15:0]};

   logic rsp_valid_ff;
   logic en;
   assign en = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   // input capture
   logic v0_ff;
   logic [bpc_pkg::UT_W-1:0] ut0_ff;
   logic [UW-1:0] up0_ff;

   // temperature multiply
   logic v1_ff;
   logic [W-1:0] x1t_ff, x1t_in, ut_diff;
   logic [UW-1:0] up1_ff;
   assign ut_diff = {16'd0, ut0_ff} - ac6;
   assign x1t_in  = W'($signed(ut_diff * ac5) >>> 15);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
      end
      if (en) begin
         ut0_ff <= req_raw_temperature;
         up0_ff <= req_raw_pressure;
         x1t_ff <= x1t_in;
         up1_ff <= up0_ff;
      end
   end

   // first divider: (mc << 11) / (x1 + md), signed via magnitudes
   logic [W-1:0] den_t, num_t, den_abs, num_abs;
   logic         qneg_t, err_t;
   assign den_t   = x1t_ff + md;
   assign num_t   = mc << 11;
   assign den_abs = den_t[W-1] ? (W'(0) - den_t) : den_t;
   assign num_abs = num_t[W-1] ? (W'(0) - num_t) : num_t;
   assign qneg_t  = den_t[W-1] ^ num_t[W-1];
   assign err_t   = (den_t == '0);

   logic          va;
   logic [W-1:0]  qa;
   logic [PA_W-1:0] pa;

   bpc_div #(.DATA_W(W), .PAY_W(PA_W)) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .in_num    (num_abs),
      .in_den    (den_abs),
      .in_pay    ({err_t, up1_ff, x1t_ff, qneg_t}),
      .out_valid (va),
      .out_quo   (qa),
      .out_pay   (pa)
   );

   logic [W-1:0] x2t, b6_in;
   assign x2t   = pa[0] ? (W'(0) - qa) : qa;
   assign b6_in = pa[W:1] + x2t - bpc_pkg::B6_OFFSET;

   logic vb0_ff, vb1_ff, vb2_ff, vb3_ff, vb4_ff;
   logic eb0_ff, eb1_ff, eb2_ff, eb3_ff, eb4_ff;
   logic [UW-1:0] upb0_ff, upb1_ff, upb2_ff, upb3_ff;
   logic [W-1:0] b6_ff, b6sq_ff, x2a_ff, x1b_ff;
   logic [W-1:0] x1a_ff, x2b_ff, x2a2_ff, x1b2_ff;
   logic [W-1:0] b3_ff, x3b_ff, b4_ff, b7_ff;
   logic [W-1:0] b6sq_in, x2a_in, x1b_in, x1a_in, x2b_in;
   logic [W-1:0] x3a, v3, b3_in, x3b_in, b4_in, b7_in;

   assign b6sq_in = W'($signed(b6_ff * b6_ff) >>> 12);
   assign x2a_in  = W'($signed(ac2 * b6_ff) >>> 11);
   assign x1b_in  = W'($signed(ac3 * b6_ff) >>> 13);
   assign x1a_in  = W'($signed(b2 * b6sq_ff) >>> 11);
   assign x2b_in  = W'($signed(b1 * b6sq_ff) >>> 16);
   assign x3a     = x1a_ff + x2a2_ff;
   assign v3      = (((ac1 << 2) + x3a) << oss_ff) + W'(2);
   assign b3_in   = v3[W-1] ? W'($signed(v3 + W'(3)) >>> 2) : (v3 >> 2);
   assign x3b_in  = W'($signed(x1b2_ff + x2b_ff + W'(2)) >>> 2);
   assign b4_in   = (ac4 * (x3b_ff + bpc_pkg::K_32768)) >> 15;
   assign b7_in   = ({{(W-UW){1'b0}}, upb3_ff} - b3_ff) * (bpc_pkg::K_50000 >> oss_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vb0_ff <= 1'b0;
         vb1_ff <= 1'b0;
         vb2_ff <= 1'b0;
         vb3_ff <= 1'b0;
         vb4_ff <= 1'b0;
      end else if (en) begin
         vb0_ff <= va;
         vb1_ff <= vb0_ff;
         vb2_ff <= vb1_ff;
         vb3_ff <= vb2_ff;
         vb4_ff <= vb3_ff;
      end
      if (en) begin
         eb0_ff  <= pa[PA_W-1];
         upb0_ff <= pa[PA_W-2:W+1];
         b6_ff   <= b6_in;
         eb1_ff  <= eb0_ff;
         upb1_ff <= upb0_ff;
         b6sq_ff <= b6sq_in;
         x2a_ff  <= x2a_in;
         x1b_ff  <= x1b_in;
         eb2_ff  <= eb1_ff;
         upb2_ff <= upb1_ff;
         x1a_ff  <= x1a_in;
         x2b_ff  <= x2b_in;
         x2a2_ff <= x2a_ff;
         x1b2_ff <= x1b_ff;
         eb3_ff  <= eb2_ff;
         upb3_ff <= upb2_ff;
         b3_ff   <= b3_in;
         x3b_ff  <= x3b_in;
         eb4_ff  <= eb3_ff;
         b4_ff   <= b4_in;
         b7_ff   <= b7_in;
      end
   end

   // second divider: b7 / b4 with the doubling placed by the size of b7
   logic          vd;
   logic [W-1:0]  qd;
   logic [1:0]    pd;
   logic          post_p, err_p;
   assign post_p = b7_ff[W-1];
   assign err_p  = eb4_ff | (b4_ff == '0);

   bpc_div #(.DATA_W(W), .PAY_W(2)) u_div_p (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vb4_ff),
      .in_num    (post_p ? b7_ff : (b7_ff << 1)),
      .in_den    (b4_ff),
      .in_pay    ({err_p, post_p}),
      .out_valid (vd),
      .out_quo   (qd),
      .out_pay   (pd)
   );

   logic vc0_ff, vc1_ff, vc2_ff;
   logic ec0_ff, ec1_ff, ec2_ff;
   logic [W-1:0] p0_ff, p1_ff, p2_ff, sq_ff, negm_ff, x1c_ff, x2c_ff;
   logic [W-1:0] p_sh, x1c_in, x2c_in, p_fin;
   assign p_sh   = W'($signed(p0_ff) >>> 8);
   assign x1c_in = W'($signed(sq_ff * bpc_pkg::K_3038) >>> 16);
   assign x2c_in = W'($signed(negm_ff) >>> 16);
   assign p_fin  = p2_ff + W'($signed(x1c_ff + x2c_ff + bpc_pkg::K_3791) >>> 4);

   logic [W-1:0] rsp_pressure_pa_ff;
   logic         rsp_divide_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc0_ff <= 1'b0;
         vc1_ff <= 1'b0;
         vc2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vc0_ff <= vd;
         vc1_ff <= vc0_ff;
         vc2_ff <= vc1_ff;
         rsp_valid_ff <= vc2_ff;
      end
      if (en) begin
         ec0_ff  <= pd[1];
         p0_ff   <= pd[0] ? (qd << 1) : qd;
         ec1_ff  <= ec0_ff;
         p1_ff   <= p0_ff;
         sq_ff   <= p_sh * p_sh;
         negm_ff <= W'(0) - (bpc_pkg::K_7357 * p0_ff);
         ec2_ff  <= ec1_ff;
         p2_ff   <= p1_ff;
         x1c_ff  <= x1c_in;
         x2c_ff  <= x2c_in;
         rsp_divide_error_ff <= ec2_ff;
         rsp_pressure_pa_ff  <= ec2_ff ? '0 : p_fin;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pressure_pa  = rsp_pressure_pa_ff;
   assign rsp_divide_error = rsp_divide_error_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_pressure_pa == '0)
      else $error("divide error with nonzero pressure");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pressure_pa))
      else $error("stalled response changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("pipeline advance mismatch");

endmodule
